### src/rrmt_pkg.sv
// Package for the range reserve minimum tree: widths, constants, sequencer
// states and the request word of the shared arithmetic unit.
// No dependencies.
package rrmt_pkg;

	localparam int DW          = 48;
	localparam int AMT_W       = 31;
	localparam int RNG_W       = 11;
	localparam int REQ_W       = 24;
	localparam int LEAVES_DEF  = 1024;

	localparam logic signed [DW-1:0] UNLOADED_CAP = 48'sd2000000000;
	// Value for padding slots beyond the last real slot; never the minimum.
	localparam logic signed [DW-1:0] PAD_CAP      = 48'sh7FFF_FFFF_FFFF;
	localparam logic [REQ_W-1:0]     REQ_MAX      = 24'hFF_FFFF;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LD_RD,
		ST_LD_ACC,
		ST_LD_WR,
		ST_AP_CHK,
		ST_AP_RD,
		ST_AP_WT,
		ST_AP_WD,
		ST_BLD_RD,
		ST_BLD_WR,
		ST_ROOT_RD,
		ST_ROOT_CHK
	} state_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MIN_ADD
	} alu_op_t;

	typedef struct packed {
		alu_op_t                op;
		logic signed [DW-1:0]   a;
		logic signed [DW-1:0]   b;
		logic signed [DW-1:0]   c;
	} alu_req_t;

endpackage

### src/rrmt_alu.sv
// Shared arithmetic unit of the tree sequencer: add, subtract, and
// minimum of two followed by an add. Depends on rrmt_pkg.
module rrmt_alu (
	input  rrmt_pkg::alu_req_t                req,
	output logic signed [rrmt_pkg::DW-1:0]    res
);

	// One wide compare and one wide add at most per operation.
	always_comb begin
		unique case (req.op)
			rrmt_pkg::ALU_ADD:     res = req.a + req.b;
			rrmt_pkg::ALU_SUB:     res = req.a - req.b;
			rrmt_pkg::ALU_MIN_ADD: res = ((req.a < req.b) ? req.a : req.b) + req.c;
			default:               res = req.a;
		endcase
	end

endmodule

### src/rrmt_node_ram.sv
// Node storage of the tree: subtree minima (two read ports) and pending
// adds (one read port), each with one write port. Depends on rrmt_pkg.
module rrmt_node_ram #(
	parameter int AW = 11
) (
	input  logic                           clk,
	input  logic                           rd_en,
	input  logic [AW-1:0]                  t_ra,
	input  logic [AW-1:0]                  t_rb,
	input  logic [AW-1:0]                  d_ra,
	input  logic                           t_we,
	input  logic [AW-1:0]                  t_wa,
	input  logic signed [rrmt_pkg::DW-1:0] t_wd,
	input  logic                           d_we,
	input  logic [AW-1:0]                  d_wa,
	input  logic signed [rrmt_pkg::DW-1:0] d_wd,
	output logic signed [rrmt_pkg::DW-1:0] t_rda,
	output logic signed [rrmt_pkg::DW-1:0] t_rdb,
	output logic signed [rrmt_pkg::DW-1:0] d_rd
);

	localparam int DEPTH = 2 ** AW;

	logic signed [rrmt_pkg::DW-1:0] tmem [DEPTH];
	logic signed [rrmt_pkg::DW-1:0] dmem [DEPTH];

	// Minimum memory: one write port and two registered read ports.
	always_ff @(posedge clk) begin
		if (t_we) begin
			tmem[t_wa] <= t_wd;
		end
		if (rd_en) begin
			t_rda <= tmem[t_ra];
			t_rdb <= tmem[t_rb];
		end
	end

	// Pending add memory: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (d_we) begin
			dmem[d_wa] <= d_wd;
		end
		if (rd_en) begin
			d_rd <= dmem[d_ra];
		end
	end

endmodule

### src/range_reserve_min_tree_core.sv
// A load sums the pending adds above its leaf, writes the leaf and rebuilds the minima above
// it; a reservation updates the nodes covering the range, then repairs two paths to the root;
// an ignored load or reservation only reads the root. One word at a time: the next word can
// be taken in the cycle after the result is registered; a stalled result holds the sequencer.
// Reset: arst_n clears control state, then a clearing pass writes all 2*N tree nodes, one per
// cycle, N = LEAVES rounded up to a power of two. Depends on rrmt_pkg, rrmt_alu, rrmt_node_ram.
module range_reserve_min_tree_core #(
	parameter int LEAVES = rrmt_pkg::LEAVES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              action,
	input  logic [rrmt_pkg::AMT_W-1:0]        amount,
	input  logic [rrmt_pkg::RNG_W-1:0]        range_low,
	input  logic [rrmt_pkg::RNG_W-1:0]        range_high,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [rrmt_pkg::DW-1:0]    global_minimum,
	output logic                              shortfall,
	output logic [rrmt_pkg::REQ_W-1:0]        first_failed_request
);

	localparam int LOG   = (LEAVES > 1) ? $clog2(LEAVES) : 1;
	localparam int AW    = LOG + 1;
	localparam int N     = 2 ** LOG;
	localparam int NODES = 2 * N;
	localparam int CW    = (LOG + 2 > rrmt_pkg::RNG_W) ? LOG + 2 : rrmt_pkg::RNG_W;
	localparam logic [AW-1:0] LEAVES_A  = AW'(LEAVES);
	localparam logic [AW-1:0] LAST_NODE = AW'(NODES - 1);
	localparam logic [AW-1:0] ROOT      = AW'(1);
	localparam logic [AW:0]   REAL_END  = (AW + 1)'(N + LEAVES);
	localparam logic [CW-1:0] LEAVES_C  = CW'(LEAVES);
	localparam logic [CW-1:0] N_C       = CW'(N);
	localparam logic [CW-1:0] ONE_C     = CW'(1);

	rrmt_pkg::state_t state_q, state_d;

	logic [AW-1:0]                  clr_q;
	logic [AW-1:0]                  lc_q;
	logic [rrmt_pkg::REQ_W-1:0]     req_q;
	logic [rrmt_pkg::REQ_W-1:0]     fail_q;
	logic                           out_valid_q;
	logic [AW:0]                    l_q, r_q;
	logic [AW-1:0]                  p1_q, p2_q, bp_q, tgt_q, leaf_q;
	logic                           second_q, is_res_q;
	logic signed [rrmt_pkg::DW-1:0] acc_q, delta_q, amount_q, gmin_q;

	logic                           rd_en, t_we, d_we;
	logic [AW-1:0]                  t_ra, t_rb, d_ra, t_wa, d_wa;
	logic signed [rrmt_pkg::DW-1:0] t_wd, d_wd, t_rda, t_rdb, d_rd;
	rrmt_pkg::alu_req_t             alu_req;
	logic signed [rrmt_pkg::DW-1:0] alu_res;

	logic                           accept, out_free;
	logic [CW-1:0]                  lo_w, hi_w, lo_c, hi_c, l_start, r_end;
	logic                           range_empty;
	logic [AW-1:0]                  leaf_next;
	logic [AW:0]                    clr_first;
	logic signed [rrmt_pkg::DW-1:0] clr_val;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != rrmt_pkg::ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// Range clipping to the real slots.
	always_comb begin
		lo_w        = CW'(range_low);
		hi_w        = CW'(range_high);
		lo_c        = (lo_w == '0) ? ONE_C : lo_w;
		hi_c        = (hi_w > LEAVES_C) ? LEAVES_C : hi_w;
		range_empty = (lo_c > hi_c);
		l_start     = N_C + lo_c - ONE_C;
		r_end       = N_C + hi_c;
	end

	assign leaf_next = {1'b1, lc_q[LOG-1:0]};

	// Reset value of a node: its first leaf decides real slot or padding.
	always_comb begin
		clr_first = '0;
		for (int k = 0; k < AW; k++) begin
			if (clr_q[k]) begin
				clr_first = {1'b0, clr_q} << (LOG - k);
			end
		end
		clr_val = (clr_first < REAL_END) ? rrmt_pkg::UNLOADED_CAP : rrmt_pkg::PAD_CAP;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rrmt_pkg::ST_CLEAR: begin
				if (clr_q == LAST_NODE) state_d = rrmt_pkg::ST_IDLE;
			end
			rrmt_pkg::ST_IDLE: begin
				if (accept) begin
					priority if (!action) begin
						state_d = (lc_q < LEAVES_A) ? rrmt_pkg::ST_LD_RD : rrmt_pkg::ST_ROOT_RD;
					end else if (fail_q != '0 || range_empty) begin
						state_d = rrmt_pkg::ST_ROOT_RD;
					end else begin
						state_d = rrmt_pkg::ST_AP_CHK;
					end
				end
			end
			rrmt_pkg::ST_LD_RD:  state_d = rrmt_pkg::ST_LD_ACC;
			rrmt_pkg::ST_LD_ACC: begin
				state_d = (bp_q == ROOT) ? rrmt_pkg::ST_LD_WR : rrmt_pkg::ST_LD_RD;
			end
			rrmt_pkg::ST_LD_WR:  state_d = rrmt_pkg::ST_BLD_RD;
			rrmt_pkg::ST_AP_CHK: begin
				priority if (l_q >= r_q) state_d = rrmt_pkg::ST_BLD_RD;
				else if (l_q[0] || r_q[0]) state_d = rrmt_pkg::ST_AP_RD;
				else state_d = rrmt_pkg::ST_AP_CHK;
			end
			rrmt_pkg::ST_AP_RD:  state_d = rrmt_pkg::ST_AP_WT;
			rrmt_pkg::ST_AP_WT:  state_d = rrmt_pkg::ST_AP_WD;
			rrmt_pkg::ST_AP_WD:  state_d = rrmt_pkg::ST_AP_CHK;
			rrmt_pkg::ST_BLD_RD: state_d = rrmt_pkg::ST_BLD_WR;
			rrmt_pkg::ST_BLD_WR: begin
				priority if (bp_q != ROOT) state_d = rrmt_pkg::ST_BLD_RD;
				else if (second_q) state_d = rrmt_pkg::ST_BLD_RD;
				else state_d = rrmt_pkg::ST_ROOT_RD;
			end
			rrmt_pkg::ST_ROOT_RD:  state_d = rrmt_pkg::ST_ROOT_CHK;
			rrmt_pkg::ST_ROOT_CHK: begin
				if (out_free) state_d = rrmt_pkg::ST_IDLE;
			end
			default: state_d = rrmt_pkg::ST_CLEAR;
		endcase
	end

	// Memory commands and the arithmetic request for each state.
	always_comb begin
		rd_en   = 1'b0;
		t_ra    = ROOT;
		t_rb    = ROOT;
		d_ra    = ROOT;
		t_we    = 1'b0;
		t_wa    = tgt_q;
		t_wd    = alu_res;
		d_we    = 1'b0;
		d_wa    = tgt_q;
		d_wd    = alu_res;
		alu_req = '{op: rrmt_pkg::ALU_ADD, a: acc_q, b: d_rd, c: '0};
		unique case (state_q)
			rrmt_pkg::ST_CLEAR: begin
				t_we = 1'b1;
				t_wa = clr_q;
				t_wd = clr_val;
				d_we = 1'b1;
				d_wa = clr_q;
				d_wd = '0;
			end
			rrmt_pkg::ST_LD_RD: begin
				rd_en = 1'b1;
				d_ra  = bp_q;
			end
			rrmt_pkg::ST_LD_ACC: begin
				alu_req = '{op: rrmt_pkg::ALU_ADD, a: acc_q, b: d_rd, c: '0};
			end
			rrmt_pkg::ST_LD_WR: begin
				alu_req = '{op: rrmt_pkg::ALU_SUB, a: amount_q, b: acc_q, c: '0};
				t_we    = 1'b1;
				t_wa    = leaf_q;
			end
			rrmt_pkg::ST_AP_RD: begin
				rd_en = 1'b1;
				t_ra  = tgt_q;
				d_ra  = tgt_q;
			end
			rrmt_pkg::ST_AP_WT: begin
				alu_req = '{op: rrmt_pkg::ALU_ADD, a: t_rda, b: delta_q, c: '0};
				t_we    = 1'b1;
			end
			rrmt_pkg::ST_AP_WD: begin
				// Leaves keep no pending add.
				alu_req = '{op: rrmt_pkg::ALU_ADD, a: d_rd, b: delta_q, c: '0};
				d_we    = !tgt_q[AW-1];
			end
			rrmt_pkg::ST_BLD_RD: begin
				rd_en = 1'b1;
				t_ra  = {bp_q[AW-2:0], 1'b0};
				t_rb  = {bp_q[AW-2:0], 1'b1};
				d_ra  = bp_q;
			end
			rrmt_pkg::ST_BLD_WR: begin
				alu_req = '{op: rrmt_pkg::ALU_MIN_ADD, a: t_rda, b: t_rdb, c: d_rd};
				t_we    = 1'b1;
				t_wa    = bp_q;
			end
			rrmt_pkg::ST_ROOT_RD: begin
				rd_en = 1'b1;
				t_ra  = ROOT;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rrmt_pkg::ST_CLEAR;
			clr_q       <= '0;
			lc_q        <= '0;
			req_q       <= '0;
			fail_q      <= '0;
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
			is_res_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == rrmt_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (accept) begin
				is_res_q <= action && (fail_q == '0);
				if (action && fail_q == '0 && req_q != rrmt_pkg::REQ_MAX) begin
					req_q <= req_q + rrmt_pkg::REQ_W'(1);
				end
				second_q <= action;
			end
			if (state_q == rrmt_pkg::ST_LD_WR) lc_q <= lc_q + AW'(1);
			if (state_q == rrmt_pkg::ST_BLD_WR && bp_q == ROOT) second_q <= 1'b0;
			// The output register fills from the root check and frees when taken.
			if (state_q == rrmt_pkg::ST_ROOT_CHK && out_free) begin
				out_valid_q <= 1'b1;
				if (is_res_q && t_rda < 0) fail_q <= req_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the sequencer.
	always_ff @(posedge clk) begin
		if (accept) begin
			amount_q <= rrmt_pkg::DW'(amount);
			delta_q  <= -rrmt_pkg::DW'(amount);
			leaf_q   <= leaf_next;
			bp_q     <= leaf_next >> 1;
			acc_q    <= '0;
			l_q      <= l_start[AW:0];
			r_q      <= r_end[AW:0];
			p1_q     <= l_start[AW:1];
			p2_q     <= AW'((r_end - ONE_C) >> 1);
		end
		unique case (state_q)
			rrmt_pkg::ST_LD_ACC: begin
				acc_q <= alu_res;
				bp_q  <= bp_q >> 1;
			end
			rrmt_pkg::ST_LD_WR: begin
				bp_q <= leaf_q >> 1;
			end
			rrmt_pkg::ST_AP_CHK: begin
				priority if (l_q >= r_q) begin
					bp_q <= p1_q;
				end else if (l_q[0]) begin
					tgt_q <= l_q[AW-1:0];
					l_q   <= l_q + (AW + 1)'(1);
				end else if (r_q[0]) begin
					tgt_q <= AW'(r_q - (AW + 1)'(1));
					r_q   <= r_q - (AW + 1)'(1);
				end else begin
					l_q <= l_q >> 1;
					r_q <= r_q >> 1;
				end
			end
			rrmt_pkg::ST_BLD_WR: begin
				bp_q <= (bp_q == ROOT) ? p2_q : (bp_q >> 1);
			end
			rrmt_pkg::ST_ROOT_CHK: begin
				if (out_free) gmin_q <= t_rda;
			end
			default: ;
		endcase
	end

	rrmt_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	rrmt_node_ram #(.AW(AW)) u_ram (
		.clk   (clk),
		.rd_en (rd_en),
		.t_ra  (t_ra),
		.t_rb  (t_rb),
		.d_ra  (d_ra),
		.t_we  (t_we),
		.t_wa  (t_wa),
		.t_wd  (t_wd),
		.d_we  (d_we),
		.d_wa  (d_wa),
		.d_wd  (d_wd),
		.t_rda (t_rda),
		.t_rdb (t_rdb),
		.d_rd  (d_rd)
	);

	assign out_valid            = out_valid_q;
	assign global_minimum       = gmin_q;
	assign shortfall            = (fail_q != '0);
	assign first_failed_request = fail_q;

endmodule

### src/rrmt_checker.sv
// Port checker for range_reserve_min_tree_core, attached by bind.
// Depends on rrmt_pkg.
module rrmt_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic signed [rrmt_pkg::DW-1:0] global_minimum,
	input logic                           shortfall,
	input logic [rrmt_pkg::REQ_W-1:0]     first_failed_request
);

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(global_minimum))
		else $error("result word changed while stalled");

	// The block works on one word at a time.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a word is in work");

	// Once a shortfall is reported it stays, with the same request number.
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		shortfall |=> shortfall && $stable(first_failed_request))
		else $error("shortfall record changed");

	// The flag and the request number agree.
	a_flag: assert property (@(posedge clk) disable iff (!arst_n)
		shortfall == (first_failed_request != '0))
		else $error("shortfall flag disagrees with request number");

endmodule

bind range_reserve_min_tree_core rrmt_checker u_rrmt_checker (.*);
